/* rtl/core/ndo_pkg.sv */
// Package for the neighbor index core: request and result structs,
// configuration register codes, boundary modes and fixed field widths.
// No dependencies.
package ndo_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned IDX_W      = 32;
  localparam int unsigned EXT_W      = 16;
  localparam int unsigned STR_W      = 32;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgRank    = 3'd0,
    CfgMode    = 3'd1,
    CfgExtent0 = 3'd2,
    CfgExtent1 = 3'd3,
    CfgExtent2 = 3'd4,
    CfgStride0 = 3'd5,
    CfgStride1 = 3'd6,
    CfgStride2 = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ModePeriodic   = 2'd0,
    ModeReflective = 2'd1,
    ModeDirichlet  = 2'd2,
    ModeNeumann    = 2'd3
  } bmode_e;

  typedef struct packed {
    logic [IDX_W-1:0]        center_index;
    logic signed [OFF_W-1:0] offset_axis0;
    logic signed [OFF_W-1:0] offset_axis1;
    logic signed [OFF_W-1:0] offset_axis2;
  } req_t;

  typedef struct packed {
    logic             neighbor_valid;
    logic             neighbor_wrapped;
    logic [IDX_W-1:0] neighbor_index;
    logic             status;
  } rsp_t;

endpackage

/* rtl/core/nd_offset_neighbor_index_core.sv */
// Top level of the stencil neighbor index core: config registers, per-axis
// divider chains, boundary resolution, stride products and final sum.
// Depends on ndo_pkg and ndo_div_chain.
//
// One request is taken every cycle (busy_o stays low) and its result appears
// on rsp_o with done_o; the receiver cannot stall it.
// The pipeline is built from three cell chains per axis: 32 cells for index /
// stride, 32 cells for that quotient mod extent, and 17 cells for the
// wrap or mirror modulo, plus five register stages around them.
// Configuration writes are always taken and must only be made while idle.
module nd_offset_neighbor_index_core #(
  parameter int unsigned MAX_RANK   = 3,
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  ndo_pkg::req_t                req_i,
  output logic                         done_o,
  output ndo_pkg::rsp_t                rsp_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ndo_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ndo_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import ndo_pkg::*;

  localparam int unsigned MW       = EXT_W + 1;
  localparam int unsigned TW       = EXT_W + 2;
  localparam int unsigned PW       = TW + STR_W + 1;
  localparam int unsigned LineA    = 2 * IDX_W;
  localparam int unsigned LineB    = MW;
  localparam int unsigned Latency  = LineA + LineB + 5;
  localparam logic [63:0] IndexLim = (64'd1 << INDEX_BITS) - 64'd1;

  typedef struct packed {
    logic [IDX_W-1:0]                   idx;
    logic [AXES-1:0][OFF_W-1:0]         off;
  } ctxa_t;

  typedef struct packed {
    logic [IDX_W-1:0]                   idx;
    logic [AXES-1:0][EXT_W-1:0]         coord;
    logic [AXES-1:0]                    neg;
    logic [AXES-1:0]                    oor;
  } ctxb_t;

  // configuration
  logic [1:0]       rank_q;
  logic [1:0]       mode_q;
  logic [EXT_W-1:0] ext_q [AXES];
  logic [STR_W-1:0] str_q [AXES];

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= 2'd1;
      mode_q <= ModePeriodic;
      for (int a = 0; a < AXES; a++) begin
        ext_q[a] <= EXT_W'(1);
        str_q[a] <= STR_W'(1);
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgRank:    rank_q   <= cfg_data_i[1:0];
        CfgMode:    mode_q   <= cfg_data_i[1:0];
        CfgExtent0: ext_q[0] <= cfg_data_i[EXT_W-1:0];
        CfgExtent1: ext_q[1] <= cfg_data_i[EXT_W-1:0];
        CfgExtent2: ext_q[2] <= cfg_data_i[EXT_W-1:0];
        CfgStride0: str_q[0] <= cfg_data_i;
        CfgStride1: str_q[1] <= cfg_data_i;
        CfgStride2: str_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid line
  logic              s0_vld_q;
  logic [LineA-1:0]  la_vld_q;
  logic              t_vld_q;
  logic [LineB-1:0]  lb_vld_q;
  logic              f_vld_q;
  logic              m_vld_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      la_vld_q <= '0;
      t_vld_q  <= 1'b0;
      lb_vld_q <= '0;
      f_vld_q  <= 1'b0;
      m_vld_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s0_vld_q <= start_i && !busy_o;
      la_vld_q <= {la_vld_q[LineA-2:0], s0_vld_q};
      t_vld_q  <= la_vld_q[LineA-1];
      lb_vld_q <= {lb_vld_q[LineB-2:0], t_vld_q};
      f_vld_q  <= lb_vld_q[LineB-1];
      m_vld_q  <= f_vld_q;
      done_q   <= m_vld_q;
    end
  end

  // accept stage and context line
  ctxa_t s0_q;
  ctxa_t la_q [LineA];

  always_ff @(posedge clk_i) begin
    s0_q.idx    <= req_i.center_index;
    s0_q.off[0] <= req_i.offset_axis0;
    s0_q.off[1] <= req_i.offset_axis1;
    s0_q.off[2] <= req_i.offset_axis2;
    la_q[0]     <= s0_q;
    for (int k = 1; k < LineA; k++) la_q[k] <= la_q[k-1];
  end

  // coordinate chains
  logic [IDX_W-1:0] quo1 [AXES];
  logic [STR_W-1:0] rem1 [AXES];
  logic [IDX_W-1:0] quo2 [AXES];
  logic [EXT_W-1:0] rem2 [AXES];
  logic [MW-1:0]    abs_q [AXES];
  logic [MW-1:0]    mod_q [AXES];
  logic [MW-1:0]    quo3 [AXES];
  logic [MW-1:0]    rem3 [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    ndo_div_chain #(.DW(IDX_W), .VW(STR_W)) u_div_stride (
      .clk_i (clk_i),
      .num_i (s0_q.idx),
      .den_i (str_q[a]),
      .quo_o (quo1[a]),
      .rem_o (rem1[a])
    );
    ndo_div_chain #(.DW(IDX_W), .VW(EXT_W)) u_mod_extent (
      .clk_i (clk_i),
      .num_i (quo1[a]),
      .den_i (ext_q[a]),
      .quo_o (quo2[a]),
      .rem_o (rem2[a])
    );
    ndo_div_chain #(.DW(MW), .VW(MW)) u_mod_target (
      .clk_i (clk_i),
      .num_i (abs_q[a]),
      .den_i (mod_q[a]),
      .quo_o (quo3[a]),
      .rem_o (rem3[a])
    );
  end

  // target stage
  ctxb_t t_d;
  ctxb_t t_q;
  ctxb_t lb_q [LineB];
  logic [MW-1:0] abs_d [AXES];
  logic [MW-1:0] mod_d [AXES];

  always_comb begin
    logic signed [TW-1:0] tgt;
    logic [MW-1:0]        period;
    t_d.idx = la_q[LineA-1].idx;
    for (int a = 0; a < AXES; a++) begin
      tgt          = $signed({2'b00, rem2[a]}) + TW'($signed(la_q[LineA-1].off[a]));
      period       = {ext_q[a] - EXT_W'(1), 1'b0};
      t_d.coord[a] = rem2[a];
      t_d.neg[a]   = tgt[TW-1];
      t_d.oor[a]   = tgt[TW-1] || (tgt >= $signed({2'b00, ext_q[a]}));
      abs_d[a]     = tgt[TW-1] ? MW'(-tgt) : tgt[MW-1:0];
      mod_d[a]     = (mode_q == ModePeriodic) ? {1'b0, ext_q[a]} : period;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    abs_q   <= abs_d;
    mod_q   <= mod_d;
    lb_q[0] <= t_q;
    for (int k = 1; k < LineB; k++) lb_q[k] <= lb_q[k-1];
  end

  // resolve stage
  logic [IDX_W-1:0]     f_idx_q;
  logic signed [TW-1:0] delta_q [AXES];
  logic                 f_wrap_q;
  logic                 f_inv_q;
  logic signed [TW-1:0] delta_d [AXES];
  logic                 f_wrap_d;
  logic                 f_inv_d;

  always_comb begin
    logic [MW-1:0] period;
    logic [MW-1:0] m;
    logic [MW-1:0] rr;
    logic [MW-1:0] tgt;
    logic          use_axis;
    f_wrap_d = 1'b0;
    f_inv_d  = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      period   = {ext_q[a] - EXT_W'(1), 1'b0};
      m        = (mode_q == ModePeriodic) ? {1'b0, ext_q[a]} : period;
      rr       = (lb_q[LineB-1].neg[a] && rem3[a] != '0) ? m - rem3[a] : rem3[a];
      if (mode_q == ModePeriodic) begin
        tgt = rr;
      end else if (ext_q[a] == EXT_W'(1)) begin
        tgt = '0;
      end else begin
        tgt = (rr >= {1'b0, ext_q[a]}) ? period - rr : rr;
      end
      use_axis   = a < int'(rank_q);
      delta_d[a] = '0;
      if (use_axis) begin
        if (ext_q[a] == '0 || str_q[a] == '0) f_inv_d = 1'b1;
        delta_d[a] = $signed({1'b0, tgt}) - $signed({2'b00, lb_q[LineB-1].coord[a]});
        if (lb_q[LineB-1].oor[a]) begin
          if (mode_q == ModeDirichlet || mode_q == ModeNeumann) f_inv_d = 1'b1;
          f_wrap_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f_idx_q  <= lb_q[LineB-1].idx;
    delta_q  <= delta_d;
    f_wrap_q <= f_wrap_d;
    f_inv_q  <= f_inv_d;
  end

  // product stage
  logic [IDX_W-1:0]     m_idx_q;
  logic signed [PW-1:0] prod_q [AXES];
  logic                 m_wrap_q;
  logic                 m_inv_q;

  always_ff @(posedge clk_i) begin
    m_idx_q  <= f_idx_q;
    m_wrap_q <= f_wrap_q;
    m_inv_q  <= f_inv_q;
    for (int a = 0; a < AXES; a++) begin
      prod_q[a] <= PW'(delta_q[a]) * PW'($signed({1'b0, str_q[a]}));
    end
  end

  // sum and range stage
  rsp_t rsp_d;
  rsp_t rsp_q;

  always_comb begin
    logic signed [63:0] sum;
    logic               bad;
    sum = $signed({32'd0, m_idx_q});
    for (int a = 0; a < AXES; a++) sum = sum + 64'(prod_q[a]);
    bad = (rank_q == 2'd0) || (int'(rank_q) > MAX_RANK) || ({32'd0, m_idx_q} > IndexLim);
    rsp_d.neighbor_valid   = 1'b0;
    rsp_d.neighbor_wrapped = 1'b0;
    rsp_d.neighbor_index   = m_idx_q;
    rsp_d.status           = 1'b0;
    if (bad) begin
      rsp_d.status = 1'b1;
    end else if (!m_inv_q) begin
      if (sum[63] || (sum > $signed(IndexLim))) begin
        rsp_d.status = 1'b1;
      end else begin
        rsp_d.neighbor_valid   = 1'b1;
        rsp_d.neighbor_wrapped = m_wrap_q;
        rsp_d.neighbor_index   = sum[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Latency done_o)
    else $error("result missing after fixed latency");

  a_valid_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.neighbor_valid |-> !rsp_o.status)
    else $error("valid neighbor with error status");

  a_wrap_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.neighbor_valid |-> !rsp_o.neighbor_wrapped)
    else $error("wrapped flag on invalid neighbor");

endmodule

/* rtl/core/ndo_div_cell.sv */
// One restoring division step: shift in a dividend bit, trial subtract,
// shift out a quotient bit. Registered. Depends on nothing.
module ndo_div_cell #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 32
) (
  input  logic          clk_i,
  input  logic [VW-1:0] rem_i,
  input  logic [DW-1:0] num_i,
  input  logic [VW-1:0] den_i,
  output logic [VW-1:0] rem_o,
  output logic [DW-1:0] num_o,
  output logic [VW-1:0] den_o
);

  logic [VW:0]   rem_sh;
  logic [VW+1:0] diff;
  logic          ge;
  logic [VW-1:0] rem_d;
  logic [DW-1:0] num_d;
  logic [VW-1:0] rem_q;
  logic [DW-1:0] num_q;
  logic [VW-1:0] den_q;

  always_comb begin
    rem_sh = {rem_i, num_i[DW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_i};
    ge     = ~diff[VW+1];
    rem_d  = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
    num_d  = {num_i[DW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_i;
  end

  assign rem_o = rem_q;
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

/* rtl/core/ndo_div_chain.sv */
// Pipelined divider: a row of DW division cells, one quotient bit each.
// Depends on ndo_div_cell. One request per cycle.
module ndo_div_chain #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 32
) (
  input  logic          clk_i,
  input  logic [DW-1:0] num_i,
  input  logic [VW-1:0] den_i,
  output logic [DW-1:0] quo_o,
  output logic [VW-1:0] rem_o
);

  logic [VW-1:0] rem_w [DW+1];
  logic [DW-1:0] num_w [DW+1];
  logic [VW-1:0] den_w [DW+1];

  assign rem_w[0] = '0;
  assign num_w[0] = num_i;
  assign den_w[0] = den_i;

  for (genvar k = 0; k < DW; k++) begin : g_cell
    ndo_div_cell #(.DW(DW), .VW(VW)) u_cell (
      .clk_i (clk_i),
      .rem_i (rem_w[k]),
      .num_i (num_w[k]),
      .den_i (den_w[k]),
      .rem_o (rem_w[k+1]),
      .num_o (num_w[k+1]),
      .den_o (den_w[k+1])
    );
  end

  assign quo_o = num_w[DW];
  assign rem_o = rem_w[DW];

endmodule

/* dv/nd_offset_neighbor_index_checker.sv */
// Checker for the neighbor index core: watches requests, config writes and
// results, predicts each result and compares it field by field.
// Depends on ndo_pkg.
module nd_offset_neighbor_index_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_o,
  input  ndo_pkg::req_t                  req_i,
  input  logic                           done_o,
  input  ndo_pkg::rsp_t                  rsp_o,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [ndo_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ndo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             errors_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ndo_pkg::*;

  logic [1:0]  rank_q;
  bmode_e      mode_q;
  logic [15:0] extent_q [3];
  logic [31:0] stride_q [3];
  rsp_t        neighbor_q [$];

  function automatic longint wrap_mod(longint a, longint m);
    longint r;
    r = a % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic rsp_t neighbor_of(req_t r);
    rsp_t   res;
    longint base, total, ext, str, off, coord, target, period;
    logic   wrapped;
    logic signed [15:0] offs [3];
    offs = '{r.offset_axis0, r.offset_axis1, r.offset_axis2};
    res = '{1'b0, 1'b0, r.center_index, 1'b0};
    base = longint'(r.center_index);
    total = 0;
    wrapped = 1'b0;
    if (rank_q == 0) begin
      res.status = 1'b1;
      return res;
    end
    for (int a = 0; a < rank_q; a++) begin
      ext = longint'(extent_q[a]);
      str = longint'(stride_q[a]);
      if (ext == 0 || str == 0) return res;
      off = longint'(offs[a]);
      coord = (base / str) % ext;
      target = coord + off;
      if (target < 0 || target >= ext) begin
        if (mode_q == ModePeriodic) begin
          target = wrap_mod(target, ext);
        end else if (mode_q == ModeReflective) begin
          if (ext == 1) begin
            target = 0;
          end else begin
            period = 2 * (ext - 1);
            target = wrap_mod(target, period);
            if (target >= ext) target = period - target;
          end
        end else begin
          return res;
        end
        wrapped = 1'b1;
      end
      total += (target - coord) * str;
    end
    base += total;
    if (base < 0 || base > longint'(32'hFFFF_FFFF)) begin
      res.status = 1'b1;
      return res;
    end
    res.neighbor_valid = 1'b1;
    res.neighbor_wrapped = wrapped;
    res.neighbor_index = base[31:0];
    return res;
  endfunction

  assign pending_o = neighbor_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      rank_q <= 2'd1;
      mode_q <= ModePeriodic;
      extent_q <= '{16'd1, 16'd1, 16'd1};
      stride_q <= '{32'd1, 32'd1, 32'd1};
      errors_o <= 0;
      neighbor_q.delete();
    end else begin
      if (done_o) begin
        if (neighbor_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, rsp_o);
          errors_o <= errors_o + 1;
        end else begin
          exp_rsp = neighbor_q.pop_front();
          if (rsp_o !== exp_rsp) begin
            $display("%0t: mismatch expected v=%b w=%b idx=%h st=%b %s v=%b w=%b idx=%h st=%b",
                     $time, exp_rsp.neighbor_valid, exp_rsp.neighbor_wrapped,
                     exp_rsp.neighbor_index, exp_rsp.status, "actual",
                     rsp_o.neighbor_valid, rsp_o.neighbor_wrapped,
                     rsp_o.neighbor_index, rsp_o.status);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_o) neighbor_q.push_back(neighbor_of(req_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgRank:    rank_q <= cfg_data_i[1:0];
          CfgMode:    mode_q <= bmode_e'(cfg_data_i[1:0]);
          CfgExtent0: extent_q[0] <= cfg_data_i[15:0];
          CfgExtent1: extent_q[1] <= cfg_data_i[15:0];
          CfgExtent2: extent_q[2] <= cfg_data_i[15:0];
          CfgStride0: stride_q[0] <= cfg_data_i;
          CfgStride1: stride_q[1] <= cfg_data_i;
          CfgStride2: stride_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

/* dv/nd_offset_neighbor_index_core_test.sv */
// Top of the neighbor index core testbench: clock, reset, config phases and
// request stimulus; the checker module predicts and compares.
// Depends on ndo_pkg, nd_offset_neighbor_index_core and the checker.
module nd_offset_neighbor_index_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ndo_pkg::*;

  logic clk_i, rst_ni, start_i, busy_o, done_o, cfg_valid_i, cfg_ready_o;
  req_t req_i;
  rsp_t rsp_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int errors, pending;
  bit calm;

  nd_offset_neighbor_index_core dut (.*);

  nd_offset_neighbor_index_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic setup_grid(logic [1:0] rnk, bmode_e mode, logic [15:0] e0,
                            logic [15:0] e1, logic [15:0] e2, logic [31:0] s0,
                            logic [31:0] s1, logic [31:0] s2);
    drain();
    write_reg(CfgRank, 32'(rnk));
    write_reg(CfgMode, 32'(mode));
    write_reg(CfgExtent0, 32'(e0));
    write_reg(CfgExtent1, 32'(e1));
    write_reg(CfgExtent2, 32'(e2));
    write_reg(CfgStride0, s0);
    write_reg(CfgStride1, s1);
    write_reg(CfgStride2, s2);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send(logic [31:0] idx, logic [15:0] o0, logic [15:0] o1,
                      logic [15:0] o2);
    while (!calm && $urandom_range(99) < 30) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= '{idx, o0, o1, o2};
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic logic [15:0] rand_off();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(6)) - 16'd3;
      default: return 16'($urandom_range(40)) - 16'd20;
    endcase
  endfunction

  initial begin
    logic [15:0] e0, e1, e2;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    calm = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(32'd0, 16'h0000, 16'h0000, 16'h0000);
    send(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
    setup_grid(2'd3, ModePeriodic, 16'd8, 16'd4, 16'd2, 32'd1, 32'd8, 32'd32);
    send(32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(32'd63, 16'h0001, 16'h0001, 16'h0001);
    send(32'd5, 16'h7FFF, 16'h8000, 16'h0003);
    send(32'hFFFF_FFFF, 16'h0001, 16'h0000, 16'h0000);
    setup_grid(2'd3, ModeReflective, 16'd1, 16'd5, 16'd65535, 32'd1, 32'd1, 32'd5);
    send(32'd3, 16'h0002, 16'hFFF9, 16'h8000);
    send(32'd10, 16'h0000, 16'h0009, 16'h7FFF);
    setup_grid(2'd2, ModeDirichlet, 16'd4, 16'd4, 16'd0, 32'd1, 32'd4, 32'd0);
    send(32'd0, 16'hFFFF, 16'h0000, 16'h1234);
    send(32'd5, 16'h0001, 16'h0001, 16'h0000);
    setup_grid(2'd1, ModeNeumann, 16'd4, 16'd1, 16'd1, 32'd1, 32'd1, 32'd1);
    send(32'd3, 16'h0001, 16'h0000, 16'h0000);
    send(32'd2, 16'h0001, 16'h0000, 16'h0000);
    setup_grid(2'd0, ModePeriodic, 16'd4, 16'd4, 16'd4, 32'd1, 32'd4, 32'd16);
    send(32'd7, 16'h0001, 16'h0001, 16'h0001);
    setup_grid(2'd2, ModePeriodic, 16'd0, 16'd4, 16'd4, 32'd1, 32'd0, 32'd16);
    send(32'd7, 16'h0001, 16'h0001, 16'h0001);
    setup_grid(2'd1, ModeReflective, 16'd65535, 16'd1, 16'd1, 32'hFFFF_FFFF, 32'd1, 32'd1);
    send(32'hFFFF_FFFF, 16'h8000, 16'h0000, 16'h0000);
    send(32'd0, 16'h7FFF, 16'h0000, 16'h0000);

    for (int phase = 0; phase < 20; phase++) begin
      e0 = 16'($urandom_range(1, 12));
      e1 = 16'($urandom_range(1, 12));
      e2 = 16'($urandom_range(1, 12));
      if ($urandom_range(9) == 0) e1 = 16'($urandom);
      if ($urandom_range(15) == 0) e0 = 16'd0;
      if (phase % 4 == 0)
        setup_grid(2'($urandom_range(3)), bmode_e'($urandom_range(3)), 16'($urandom),
                   16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
      else
        setup_grid(2'($urandom_range(1, 3)), bmode_e'($urandom_range(3)), e0, e1, e2,
                   32'd1, 32'(e0), 32'(e0) * 32'(e1));
      calm = (phase == 10);
      for (int k = 0; k < 52; k++) begin
        if ($urandom_range(9) == 0)
          send($urandom, 16'($urandom), 16'($urandom), 16'($urandom));
        else
          send(32'($urandom_range(int'(e0) * int'(e1) * int'(e2))), rand_off(),
               rand_off(), rand_off());
      end
    end

    calm = 1'b0;
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
